>>> rtl/core/set_dedup_with_optional_sort_defines.svh
// assertion macros shared by the duplicate-removal block
// expects clk and arst_n in the scope of each use
`ifndef SET_DEDUP_WITH_OPTIONAL_SORT_DEFINES_SVH
`define SET_DEDUP_WITH_OPTIONAL_SORT_DEFINES_SVH

// condition holds on every edge out of reset
`define SDOS_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SDOS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SDOS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/sdos_pkg.sv
// shared types and constants of the duplicate-removal block
// no dependencies
package sdos_pkg;

	localparam int DEF_MAX_UNIQUE = 64;
	localparam int DEF_DATA_WIDTH = 32;
	localparam int APB_ADDR_W     = 3;
	localparam int APB_DATA_W     = 32;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_SORT_ENABLE     = 1'b0,
		REG_SORT_DESCENDING = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SORT,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     phase;
		logic     descending;
		logic     any_match;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_SORT,
		ST_DRAIN
	} state_t;

endpackage

>>> rtl/core/sdos_cell.sv
// one storage cell of the unique-value chain: compare, fill, compare-swap, shift
// depends on sdos_pkg
module sdos_cell #(
	parameter int DATA_WIDTH = sdos_pkg::DEF_DATA_WIDTH,
	parameter bit IS_ODD     = 1'b0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sdos_pkg::cell_cmd_t   cmd,
	input  logic [DATA_WIDTH-1:0] data,
	input  logic [DATA_WIDTH-1:0] prev_value,
	input  logic                  prev_valid,
	input  logic                  prev_swap,
	input  logic [DATA_WIDTH-1:0] next_value,
	input  logic                  next_valid,
	output logic [DATA_WIDTH-1:0] value,
	output logic                  valid,
	output logic                  match,
	output logic                  swap_next
);

	logic [DATA_WIDTH-1:0] value_q;
	logic                  valid_q;
	logic                  is_left;
	logic                  goes_after;

	always_comb begin
		match      = valid_q && (value_q == data);
		is_left    = (cmd.phase == IS_ODD);
		goes_after = cmd.descending ? ($signed(value_q) < $signed(next_value))
		                            : ($signed(value_q) > $signed(next_value));
		swap_next  = (cmd.op == sdos_pkg::CELL_SORT) && is_left && valid_q && next_valid
		             && goes_after;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				sdos_pkg::CELL_HOLD: begin
				end
				sdos_pkg::CELL_INSERT: begin
					// first empty cell takes a value nobody matched
					if (!cmd.any_match && prev_valid && !valid_q) valid_q <= 1'b1;
				end
				sdos_pkg::CELL_SORT: begin
				end
				sdos_pkg::CELL_SHIFT: begin
					valid_q <= next_valid;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			sdos_pkg::CELL_HOLD: begin
			end
			sdos_pkg::CELL_INSERT: begin
				if (!cmd.any_match && prev_valid && !valid_q) value_q <= data;
			end
			sdos_pkg::CELL_SORT: begin
				if (swap_next) value_q <= next_value;
				else if (!is_left && prev_swap) value_q <= prev_value;
			end
			sdos_pkg::CELL_SHIFT: begin
				value_q <= next_value;
			end
		endcase
	end

	assign value = value_q;
	assign valid = valid_q;

endmodule

>>> rtl/core/sdos_ctrl.sv
// sequencer of the duplicate-removal block: config registers, collect/sort/drain
// depends on sdos_pkg and the assertion macro header
`include "set_dedup_with_optional_sort_defines.svh"

module sdos_ctrl #(
	parameter int MAX_UNIQUE = sdos_pkg::DEF_MAX_UNIQUE,
	localparam int CNT_W     = $clog2(MAX_UNIQUE + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sdos_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sdos_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sdos_pkg::APB_DATA_W-1:0] prdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            last_of_set,
	input  logic                            out_ready,
	output logic                            out_valid,
	input  logic                            any_match,
	input  logic                            full,
	output sdos_pkg::cell_cmd_t             cmd,
	output logic [CNT_W-1:0]                unique_count,
	output logic                            last_result,
	output logic                            overflow
);

	sdos_pkg::state_t   state_q, state_nxt;
	logic [CNT_W-1:0]   total_q, rnd_q, pop_q, total_add;
	logic               ovf_q, sort_en_q, sort_desc_q;
	logic               acc_in, add_new, drop_new, pop_last;
	sdos_pkg::reg_idx_t reg_idx;

	assign reg_idx = sdos_pkg::reg_idx_t'(paddr[2]);

	always_comb begin
		in_ready  = (state_q == sdos_pkg::ST_COLLECT);
		acc_in    = in_valid && in_ready;
		add_new   = acc_in && !any_match && !full;
		drop_new  = acc_in && !any_match && full;
		total_add = total_q + CNT_W'(add_new);
		pop_last  = (pop_q == total_q - CNT_W'(1));

		state_nxt      = state_q;
		out_valid      = 1'b0;
		cmd.op         = sdos_pkg::CELL_HOLD;
		cmd.phase      = rnd_q[0];
		cmd.descending = sort_desc_q;
		cmd.any_match  = any_match;

		unique case (state_q)
			sdos_pkg::ST_COLLECT: begin
				if (acc_in) begin
					cmd.op = sdos_pkg::CELL_INSERT;
					if (last_of_set) begin
						if (sort_en_q && (total_add > CNT_W'(1))) state_nxt = sdos_pkg::ST_SORT;
						else state_nxt = sdos_pkg::ST_DRAIN;
					end
				end
			end
			sdos_pkg::ST_SORT: begin
				// odd-even transposition, one round per stored value
				cmd.op = sdos_pkg::CELL_SORT;
				if (rnd_q == total_q - CNT_W'(1)) state_nxt = sdos_pkg::ST_DRAIN;
			end
			sdos_pkg::ST_DRAIN: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.op = sdos_pkg::CELL_SHIFT;
					if (pop_last) state_nxt = sdos_pkg::ST_COLLECT;
				end
			end
			default: begin
				state_nxt = sdos_pkg::ST_COLLECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sdos_pkg::ST_COLLECT;
			total_q     <= '0;
			rnd_q       <= '0;
			pop_q       <= '0;
			ovf_q       <= 1'b0;
			sort_en_q   <= 1'b0;
			sort_desc_q <= 1'b0;
		end else begin
			state_q <= state_nxt;

			if (state_q == sdos_pkg::ST_SORT) rnd_q <= rnd_q + CNT_W'(1);
			else rnd_q <= '0;

			if (state_q == sdos_pkg::ST_DRAIN) begin
				if (out_ready) begin
					if (pop_last) begin
						pop_q   <= '0;
						total_q <= '0;
						ovf_q   <= 1'b0;
					end else begin
						pop_q <= pop_q + CNT_W'(1);
					end
				end
			end else begin
				pop_q <= '0;
				if (acc_in) total_q <= total_add;
				if (drop_new) ovf_q <= 1'b1;
			end

			if (psel && penable && pwrite) begin
				unique case (reg_idx)
					sdos_pkg::REG_SORT_ENABLE:     sort_en_q   <= pwdata[0];
					sdos_pkg::REG_SORT_DESCENDING: sort_desc_q <= pwdata[0];
				endcase
			end
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			sdos_pkg::REG_SORT_ENABLE:     prdata[0] = sort_en_q;
			sdos_pkg::REG_SORT_DESCENDING: prdata[0] = sort_desc_q;
		endcase
	end

	assign unique_count = total_q;
	assign last_result  = pop_last;
	assign overflow     = ovf_q;

	`SDOS_ASSERT_ALWAYS(a_total_in_range, total_q <= CNT_W'(MAX_UNIQUE), "unique total beyond capacity")
	`SDOS_ASSERT_IMPLY(a_ovf_only_full, ovf_q, total_q == CNT_W'(MAX_UNIQUE), "overflow while store not full")
	`SDOS_ASSERT_NEXT(a_run_end_clears, out_valid && out_ready && last_result, in_ready && (total_q == '0) && !ovf_q, "run end did not clear state")
	`SDOS_ASSERT_NEXT(a_last_closes_input, acc_in && last_of_set, !in_ready, "input still open after last item")

endmodule

>>> rtl/core/set_dedup_with_optional_sort.sv
// Order-preserving duplicate removal with optional sort.
// Input channel (value, last_of_set; in_valid/in_ready): one element per item. Every
// element is compared in the same cycle against all kept uniques in a chain of cells;
// a new value fills the next empty cell. Elements are taken one per cycle while
// collecting. A new value arriving with all MAX_UNIQUE cells full is dropped and raises
// overflow for the run.
// The item carrying last_of_set closes the set. With sorting off the first result is
// ready the next cycle; with sorting on, the chain first runs n rounds of neighbor
// compare-swap (n = unique count, skipped for n = 1) before the first result comes.
// Output channel (unique_value, unique_count, last_result, overflow; out_valid/
// out_ready): n items, one per cycle the receiver takes them, shifted out of cell 0.
// A stalled receiver simply holds the chain; no new element is taken until the last
// result of the run is delivered.
// Config via the APB port: sort_enable at 0x0, sort_descending at 0x4, bit 0 each.
// Reset empties the chain, clears count, overflow and both config bits.
// depends on sdos_pkg, sdos_cell, sdos_ctrl and the assertion macro header
`include "set_dedup_with_optional_sort_defines.svh"

module set_dedup_with_optional_sort #(
	parameter int MAX_UNIQUE = sdos_pkg::DEF_MAX_UNIQUE,
	parameter int DATA_WIDTH = sdos_pkg::DEF_DATA_WIDTH,
	localparam int CNT_W     = $clog2(MAX_UNIQUE + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sdos_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sdos_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sdos_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [DATA_WIDTH-1:0]    value,
	input  logic                            last_of_set,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [DATA_WIDTH-1:0]    unique_value,
	output logic [CNT_W-1:0]                unique_count,
	output logic                            last_result,
	output logic                            overflow
);

	sdos_pkg::cell_cmd_t   cmd;
	logic [DATA_WIDTH-1:0] cell_value [MAX_UNIQUE];
	logic [MAX_UNIQUE-1:0] valid_vec;
	logic [MAX_UNIQUE-1:0] match_vec;
	logic [MAX_UNIQUE-1:0] swap_vec;
	logic                  any_match;

	assign pready    = 1'b1;
	assign any_match = |match_vec;

	sdos_ctrl #(
		.MAX_UNIQUE(MAX_UNIQUE)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.last_of_set  (last_of_set),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.any_match    (any_match),
		.full         (valid_vec[MAX_UNIQUE-1]),
		.cmd          (cmd),
		.unique_count (unique_count),
		.last_result  (last_result),
		.overflow     (overflow)
	);

	for (genvar k = 0; k < MAX_UNIQUE; k++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_value, next_value;
		logic                  prev_valid, prev_swap, next_valid;

		if (k == 0) begin : g_head
			assign prev_value = '0;
			assign prev_valid = 1'b1;
			assign prev_swap  = 1'b0;
		end else begin : g_body
			assign prev_value = cell_value[k-1];
			assign prev_valid = valid_vec[k-1];
			assign prev_swap  = swap_vec[k-1];
		end

		if (k == MAX_UNIQUE - 1) begin : g_tail
			assign next_value = '0;
			assign next_valid = 1'b0;
		end else begin : g_link
			assign next_value = cell_value[k+1];
			assign next_valid = valid_vec[k+1];
		end

		sdos_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.IS_ODD    (k % 2 == 1)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.data       (value),
			.prev_value (prev_value),
			.prev_valid (prev_valid),
			.prev_swap  (prev_swap),
			.next_value (next_value),
			.next_valid (next_valid),
			.value      (cell_value[k]),
			.valid      (valid_vec[k]),
			.match      (match_vec[k]),
			.swap_next  (swap_vec[k])
		);
	end

	assign unique_value = cell_value[0];

	`SDOS_ASSERT_ALWAYS(a_valid_prefix, ((valid_vec >> 1) & ~valid_vec) == '0, "cell chain has a hole")
	`SDOS_ASSERT_IMPLY(a_count_matches_cells, in_ready, $countones(valid_vec) == unique_count, "count differs from filled cells")
	`SDOS_ASSERT_IMPLY(a_head_filled, out_valid, valid_vec[0], "result shown from an empty head cell")

endmodule

>>> sim/set_dedup_with_optional_sort_tb.sv
// testbench for set_dedup_with_optional_sort: random sets with duplicates, store-full
// and overflow runs, and all sort settings, checked against a predictor in a small class
// depends on sdos_pkg and the set_dedup_with_optional_sort rtl
module set_dedup_with_optional_sort_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEEP_MAX     = sdos_pkg::DEF_MAX_UNIQUE;
	localparam int DW           = sdos_pkg::DEF_DATA_WIDTH;
	localparam int CNT_W        = $clog2(KEEP_MAX + 1);
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int SET_ITEMS    = 10;

	localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MIXED_SET [6] = '{3, -7, VAL_MAX, VAL_MIN, 0, 3};

	typedef struct {
		logic signed [DW-1:0] value;
		logic [CNT_W-1:0]     count;
		logic                 last;
		logic                 ovf;
	} unique_result_t;

	// keeps the unique values of the open set and the results owed for closed sets
	class dedup_tracker;
		logic signed [DW-1:0] kept [KEEP_MAX];
		int unsigned          kept_n;
		bit                   dropped_new;
		bit                   sort_on;
		bit                   sort_desc;
		unique_result_t       expected_uniques [$];
		int                   errors;

		function void write_reg(sdos_pkg::reg_idx_t idx, logic [sdos_pkg::APB_DATA_W-1:0] d);
			case (idx)
				sdos_pkg::REG_SORT_ENABLE: sort_on = d[0];
				sdos_pkg::REG_SORT_DESCENDING: sort_desc = d[0];
				default: ;
			endcase
		endfunction

		function void take_element(logic signed [DW-1:0] v, logic closes);
			logic signed [DW-1:0] order [KEEP_MAX];
			logic signed [DW-1:0] key;
			unique_result_t r;
			bit seen;
			int i;
			int j;
			seen = 0;
			for (i = 0; i < kept_n; i++)
				if (kept[i] == v)
					seen = 1;
			if (!seen) begin
				if (kept_n < KEEP_MAX) begin
					kept[kept_n] = v;
					kept_n++;
				end else begin
					dropped_new = 1;
				end
			end
			if (!closes)
				return;
			for (i = 0; i < kept_n; i++)
				order[i] = kept[i];
			if (sort_on) begin
				for (i = 1; i < kept_n; i++) begin
					key = order[i];
					j = i;
					while (j > 0 && (sort_desc ? order[j-1] < key : order[j-1] > key)) begin
						order[j] = order[j-1];
						j--;
					end
					order[j] = key;
				end
			end
			for (i = 0; i < kept_n; i++) begin
				r.value = order[i];
				r.count = kept_n[CNT_W-1:0];
				r.last  = (i == kept_n - 1);
				r.ovf   = dropped_new;
				expected_uniques.push_back(r);
			end
			kept_n = 0;
			dropped_new = 0;
		endfunction

		function void check_unique(unique_result_t got);
			unique_result_t want;
			if (expected_uniques.size() == 0) begin
				$error("unexpected item: value %0d count %0d", got.value, got.count);
				errors++;
				return;
			end
			want = expected_uniques.pop_front();
			if (got.value !== want.value) begin
				$error("unique_value: expected %0d, got %0d", want.value, got.value);
				errors++;
			end
			if (got.count !== want.count) begin
				$error("unique_count: expected %0d, got %0d", want.count, got.count);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last_result: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
			if (got.ovf !== want.ovf) begin
				$error("overflow: expected %0d, got %0d", want.ovf, got.ovf);
				errors++;
			end
		endfunction

		function int owed();
			return expected_uniques.size();
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [sdos_pkg::APB_ADDR_W-1:0]   paddr;
	logic [sdos_pkg::APB_DATA_W-1:0]   pwdata;
	logic [sdos_pkg::APB_DATA_W-1:0]   prdata;
	logic                              pready;
	logic                              in_valid;
	logic                              in_ready;
	logic signed [DW-1:0]              value;
	logic                              last_of_set;
	logic                              out_valid;
	logic                              out_ready;
	logic signed [DW-1:0]              unique_value;
	logic [CNT_W-1:0]                  unique_count;
	logic                              last_result;
	logic                              overflow;

	dedup_tracker tracker;
	int unsigned  send_idle_pct;
	int unsigned  recv_idle_pct;
	int unsigned  phase_items;
	int unsigned  cycles;
	int unsigned  hold_left;
	bit           hold_req;

	set_dedup_with_optional_sort i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.last_of_set  (last_of_set),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.unique_value (unique_value),
		.unique_count (unique_count),
		.last_result  (last_result),
		.overflow     (overflow)
	);

	initial clk = 1'b0;
	always #4ns clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("set_dedup_with_optional_sort_tb: errors");
			$finish;
		end
	end

	task automatic send_item(input logic signed [DW-1:0] v, input logic closes);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid    <= 1'b1;
		value       <= v;
		last_of_set <= closes;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.take_element(v, closes);
		phase_items++;
	endtask

	// sender goes quiet until every owed result is back and the block has settled
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tracker.owed() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input sdos_pkg::reg_idx_t idx,
	                         input logic [sdos_pkg::APB_DATA_W-1:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.write_reg(idx, d);
		@(posedge clk);
	endtask

	// upper register bits are random, only bit 0 counts
	task automatic set_sorting(input bit en, input bit desc);
		wait_drained();
		apb_write(sdos_pkg::REG_SORT_ENABLE, {31'($urandom_range(32'h7fff_ffff)), en});
		apb_write(sdos_pkg::REG_SORT_DESCENDING, {31'($urandom_range(32'h7fff_ffff)), desc});
	endtask

	task automatic send_random_set();
		logic signed [DW-1:0] pool [8];
		logic signed [DW-1:0] v;
		int unsigned kind;
		int unsigned len;
		int k;
		kind = $urandom_range(99);
		len = (kind < 15) ? $urandom_range(1, 3) : $urandom_range(2, 16);
		for (k = 0; k < 8; k++)
			pool[k] = $urandom;
		if (kind[0])
			pool[0] = VAL_MIN;
		if (kind[1])
			pool[1] = VAL_MAX;
		for (k = 0; k < len; k++) begin
			if (kind < 40) begin
				v = $urandom;
			end else if (kind < 70) begin
				v = pool[$urandom_range(7)];
			end else begin
				v = $urandom_range(16);
				v = v - 8;
			end
			send_item(v, k == len - 1);
		end
	endtask

	// distinct values first, then repeats of values already kept
	task automatic send_wide_set(input int unsigned distinct, input int unsigned repeats);
		logic [DW-1:0] base;
		logic [DW-1:0] stride;
		int unsigned k;
		int unsigned span;
		base   = $urandom;
		stride = $urandom | 1;
		span   = (distinct < KEEP_MAX) ? distinct : KEEP_MAX;
		for (k = 0; k < distinct; k++)
			send_item(base + k * stride, repeats == 0 && k == distinct - 1);
		for (k = 0; k < repeats; k++)
			send_item(base + $urandom_range(span - 1) * stride, k == repeats - 1);
	endtask

	initial begin
		unique_result_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.value = unique_value;
				got.count = unique_count;
				got.last  = last_result;
				got.ovf   = overflow;
				tracker.check_unique(got);
			end
			if (hold_req && out_valid && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int phase;
		int k;
		tracker     = new();
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		in_valid    = 1'b0;
		value       = '0;
		last_of_set = 1'b0;
		out_ready   = 1'b0;
		cycles      = 0;
		hold_left   = 0;
		hold_req    = 0;
		send_idle_pct = 30;
		recv_idle_pct = 56;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single element, extremes with repeats closing on a repeat, sort both ways
		send_item(VAL_MIN, 1'b1);
		send_item(VAL_MAX, 1'b0);
		send_item(VAL_MAX, 1'b0);
		send_item(0, 1'b0);
		send_item(-1, 1'b0);
		send_item(VAL_MIN, 1'b0);
		send_item(0, 1'b0);
		send_item(-1, 1'b1);
		set_sorting(1'b1, 1'b0);
		for (k = 0; k < 6; k++)
			send_item(MIXED_SET[k], k == 5);
		set_sorting(1'b1, 1'b1);
		for (k = 0; k < 6; k++)
			send_item(MIXED_SET[k], k == 5);

		for (phase = 0; phase < 6; phase++) begin
			case (phase / 2)
				0: begin
					send_idle_pct = 30;
					recv_idle_pct = 56;
				end
				1: begin
					send_idle_pct = 56;
					recv_idle_pct = 30;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (phase)
				0: set_sorting(1'b1, 1'b0);
				1: set_sorting(1'b1, 1'b1);
				2: set_sorting(1'b0, 1'b1);
				3: set_sorting(1'b1, 1'b1);
				4: set_sorting(1'b0, 1'b0);
				default: set_sorting(1'b1, 1'b0);
			endcase
			phase_items = 0;
			if (phase == 3)
				hold_req = 1;
			// overflow while sorting, then a store filled exactly without sorting
			if (phase == 1)
				send_wide_set(66, 2);
			if (phase == 2)
				send_wide_set(KEEP_MAX, 3);
			phase_items = 0;
			while (phase_items < SET_ITEMS)
				send_random_set();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.owed() == 0) begin
			$display("set_dedup_with_optional_sort_tb: clean");
		end else begin
			$display("set_dedup_with_optional_sort_tb: errors");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/sdos_pkg.sv
rtl/core/sdos_cell.sv
rtl/core/sdos_ctrl.sv
rtl/core/set_dedup_with_optional_sort.sv
sim/set_dedup_with_optional_sort_tb.sv
